[rtl/gibs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gibs_pkg: shared types and constants for greedy IoU box suppression
// Word layouts of the request and response channels, the stored box entry
// and the fixed field widths.
// ----------------------------------------------------------------------------
package gibs_pkg;

   localparam int COORD_BITS       = 12;
   localparam int DIM_BITS         = 11;
   localparam int CLASS_BITS       = 8;
   localparam int THR_BITS         = 9;
   localparam int INDEX_BITS       = 16;
   localparam int KEPT_TOTAL_BITS  = 7;
   localparam int MAX_KEPT_DEFAULT = 64;

   // threshold is in units of 1/256
   localparam int THR_SHIFT        = 8;
   localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(128);

   localparam int AREA_BITS = 2 * DIM_BITS;
   localparam int UNI_BITS  = AREA_BITS + 1;
   localparam int PROD_BITS = UNI_BITS + THR_BITS;

   typedef logic [KEPT_TOTAL_BITS-1:0] kept_total_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] box_left;
      logic signed [COORD_BITS-1:0] box_top;
      logic [DIM_BITS-1:0]          box_width;
      logic [DIM_BITS-1:0]          box_height;
      logic [CLASS_BITS-1:0]        class_label;
      logic                         last_box;
   } req_type;

   typedef struct packed {
      logic                       kept;
      logic [INDEX_BITS-1:0]      candidate_index;
      kept_total_type             kept_total;
      logic                       list_overflow;
      logic                       frame_end;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] box_left;
      logic signed [COORD_BITS-1:0] box_top;
      logic [DIM_BITS-1:0]          box_width;
      logic [DIM_BITS-1:0]          box_height;
      logic [CLASS_BITS-1:0]        class_label;
      logic [AREA_BITS-1:0]         area;
   } kept_entry_type;

endpackage

`default_nettype wire

[rtl/greedy_iou_box_suppression.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_iou_box_suppression: per-class greedy non-maximum suppression
//
//   channel | ports                           | handshake
//   --------+---------------------------------+---------------------------------
//   request | start, busy, req_box            | word taken when start && !busy
//   result  | rsp_valid, rsp_result           | one-cycle strobe, always taken
//   config  | csr_write_enable, csr_write_data| written when enable is high
//
// For each candidate, busy covers the candidate area step and a scan of the
// stored boxes; each stored box of the same class also takes the intersection,
// threshold and compare steps. The scan stops at the first suppressing box,
// which saves the closing scan step. The single shared multiplier (candidate
// area, intersection, threshold times union) serves all three products.
// The result strobe is high in the same cycle that busy falls, and a new word
// may be taken in that same cycle. Synchronous reset clears the list and the
// frame position and loads the threshold with 128. The receiver cannot stall.
// ----------------------------------------------------------------------------
module greedy_iou_box_suppression #(
   parameter int MAX_KEPT = gibs_pkg::MAX_KEPT_DEFAULT
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire gibs_pkg::req_type        req_box,
   output logic                          rsp_valid,
   output gibs_pkg::rsp_type             rsp_result,
   input  wire                           csr_write_enable,
   input  wire [gibs_pkg::THR_BITS-1:0]  csr_write_data
);

   import gibs_pkg::*;

   localparam int ADDR_BITS = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int KCW       = $clog2(MAX_KEPT + 1);
   localparam int MUL_BITS  = UNI_BITS + DIM_BITS;

   typedef enum logic [2:0] {
      IDLE,
      AREA,
      SCAN,
      MUL_I,
      MUL_T,
      CMP,
      DONE
   } state_type;

   state_type state_ff, state_in;

   logic [THR_BITS-1:0]   thr_ff, thr_in;
   req_type               cand_ff, cand_in;
   logic [AREA_BITS-1:0]  area_a_ff, area_a_in;
   logic [DIM_BITS-1:0]   iw_ff, iw_in;
   logic [DIM_BITS-1:0]   ih_ff, ih_in;
   logic [AREA_BITS-1:0]  inter_ff, inter_in;
   logic [PROD_BITS-1:0]  thr_prod_ff, thr_prod_in;
   logic                  keep_ff, keep_in;
   logic [KCW-1:0]        index_ff, index_in;
   logic [KCW-1:0]        kept_count_ff, kept_count_in;
   logic [INDEX_BITS-1:0] frame_pos_ff, frame_pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   kept_entry_type        mem [MAX_KEPT];
   kept_entry_type        rd_data_ff;
   kept_entry_type        wr_entry;
   logic                  mem_write;

   logic [UNI_BITS-1:0]   mul_x;
   logic [DIM_BITS-1:0]   mul_y;
   logic [MUL_BITS-1:0]   mul_p;
   logic [UNI_BITS-1:0]   uni;
   logic [PROD_BITS-1:0]  inter_scaled;
   logic [KCW-1:0]        kept_count_new;

   // overlap of two 1-D spans, zero when they do not meet
   function automatic logic [DIM_BITS-1:0] overlap_len(
      input logic signed [COORD_BITS-1:0] a0,
      input logic [DIM_BITS-1:0]          alen,
      input logic signed [COORD_BITS-1:0] b0,
      input logic [DIM_BITS-1:0]          blen
   );
      logic signed [COORD_BITS:0] a_s, b_s, al_s, bl_s, lo, ea, eb, hi, diff;
      a_s  = $signed({a0[COORD_BITS-1], a0});
      b_s  = $signed({b0[COORD_BITS-1], b0});
      al_s = $signed({{(COORD_BITS + 1 - DIM_BITS){1'b0}}, alen});
      bl_s = $signed({{(COORD_BITS + 1 - DIM_BITS){1'b0}}, blen});
      lo   = (a_s > b_s) ? a_s : b_s;
      ea   = a_s + al_s;
      eb   = b_s + bl_s;
      hi   = (ea < eb) ? ea : eb;
      diff = hi - lo;
      overlap_len = (hi > lo) ? diff[DIM_BITS-1:0] : '0;
   endfunction

   assign busy       = (state_ff != IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   // shared multiplier
   always_comb begin
      mul_x = UNI_BITS'(cand_ff.box_width);
      mul_y = cand_ff.box_height;
      unique case (state_ff)
         MUL_I: begin
            mul_x = UNI_BITS'(iw_ff);
            mul_y = ih_ff;
         end
         MUL_T: begin
            mul_x = uni;
            mul_y = DIM_BITS'(thr_ff);
         end
         default: begin
            mul_x = UNI_BITS'(cand_ff.box_width);
            mul_y = cand_ff.box_height;
         end
      endcase
      mul_p = MUL_BITS'(mul_x) * MUL_BITS'(mul_y);
   end

   always_comb begin
      uni = UNI_BITS'(area_a_ff) + UNI_BITS'(rd_data_ff.area) - UNI_BITS'(inter_ff);
      if (uni == '0) begin
         uni = UNI_BITS'(1);
      end
      inter_scaled = PROD_BITS'({inter_ff, {THR_SHIFT{1'b0}}});
   end

   always_comb begin
      wr_entry.box_left    = cand_ff.box_left;
      wr_entry.box_top     = cand_ff.box_top;
      wr_entry.box_width   = cand_ff.box_width;
      wr_entry.box_height  = cand_ff.box_height;
      wr_entry.class_label = cand_ff.class_label;
      wr_entry.area        = area_a_ff;
   end

   always_comb begin
      state_in       = state_ff;
      thr_in         = thr_ff;
      cand_in        = cand_ff;
      area_a_in      = area_a_ff;
      iw_in          = iw_ff;
      ih_in          = ih_ff;
      inter_in       = inter_ff;
      thr_prod_in    = thr_prod_ff;
      keep_in        = keep_ff;
      index_in       = index_ff;
      kept_count_in  = kept_count_ff;
      frame_pos_in   = frame_pos_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      mem_write      = 1'b0;
      kept_count_new = kept_count_ff;

      if (csr_write_enable) begin
         thr_in = csr_write_data;
      end

      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cand_in  = req_box;
               keep_in  = 1'b1;
               index_in = '0;
               state_in = AREA;
            end
         end
         AREA: begin
            area_a_in = mul_p[AREA_BITS-1:0];
            state_in  = SCAN;
         end
         SCAN: begin
            if (index_ff == kept_count_ff) begin
               state_in = DONE;
            end else if (rd_data_ff.class_label != cand_ff.class_label) begin
               index_in = index_ff + 1'b1;
            end else begin
               iw_in    = overlap_len(cand_ff.box_left, cand_ff.box_width,
                                      rd_data_ff.box_left, rd_data_ff.box_width);
               ih_in    = overlap_len(cand_ff.box_top, cand_ff.box_height,
                                      rd_data_ff.box_top, rd_data_ff.box_height);
               state_in = MUL_I;
            end
         end
         MUL_I: begin
            inter_in = mul_p[AREA_BITS-1:0];
            state_in = MUL_T;
         end
         MUL_T: begin
            thr_prod_in = mul_p[PROD_BITS-1:0];
            state_in    = CMP;
         end
         CMP: begin
            // drop the candidate at the first box that overlaps too much
            if (inter_scaled > thr_prod_ff) begin
               keep_in  = 1'b0;
               state_in = DONE;
            end else begin
               index_in = index_ff + 1'b1;
               state_in = SCAN;
            end
         end
         DONE: begin
            rsp_in.list_overflow = 1'b0;
            if (keep_ff) begin
               if (kept_count_ff != KCW'(MAX_KEPT)) begin
                  mem_write      = 1'b1;
                  kept_count_new = kept_count_ff + 1'b1;
               end else begin
                  rsp_in.list_overflow = 1'b1;
               end
            end
            rsp_in.kept            = keep_ff;
            rsp_in.candidate_index = frame_pos_ff;
            rsp_in.kept_total      = kept_total_type'(kept_count_new);
            rsp_in.frame_end       = cand_ff.last_box;
            rsp_valid_in           = 1'b1;
            kept_count_in          = kept_count_new;
            if (frame_pos_ff != '1) begin
               frame_pos_in = frame_pos_ff + 1'b1;
            end
            if (cand_ff.last_box) begin
               kept_count_in = '0;
               frame_pos_in  = '0;
            end
            state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         thr_ff        <= THR_RESET;
         kept_count_ff <= '0;
         frame_pos_ff  <= '0;
         index_ff      <= '0;
         keep_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         thr_ff        <= thr_in;
         kept_count_ff <= kept_count_in;
         frame_pos_ff  <= frame_pos_in;
         index_ff      <= index_in;
         keep_ff       <= keep_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cand_ff     <= cand_in;
      area_a_ff   <= area_a_in;
      iw_ff       <= iw_in;
      ih_ff       <= ih_in;
      inter_ff    <= inter_in;
      thr_prod_ff <= thr_prod_in;
      rsp_ff      <= rsp_in;
   end

   // kept list; read address follows the next index so data lines up with it
   always_ff @(posedge clock) begin
      if (mem_write) begin
         mem[kept_count_ff[ADDR_BITS-1:0]] <= wr_entry;
      end
      rd_data_ff <= mem[index_in[ADDR_BITS-1:0]];
   end

endmodule

`default_nettype wire
